[rtl/wcg_pkg.sv]
// shared types, constants and fixed-point helpers of the window coefficient generator
`default_nettype none
package wcg_pkg;

	localparam int LEN_W     = 13;
	localparam int TYPE_W    = 4;
	localparam int IDX_W     = 12;
	localparam int WEIGHT_W  = 18;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_LENGTH    = 4096;
	localparam int FRACTION_BITS = 16;

	// quotient of i*2^33/n, one bit per divider stage
	localparam int QUO_W   = 33;
	localparam int DIV_LAT = QUO_W;
	localparam int SC_LAT  = 8;
	localparam int HORNER_N = 4;

	typedef logic signed [31:0] q30_t;

	localparam q30_t Q_ONE      = 32'sd1073741824;
	localparam q30_t INV_PI_Q30 = 32'sd341782638;
	localparam q30_t C_054      = 32'sd579820585;
	localparam q30_t C_046      = 32'sd493921239;
	localparam q30_t C_042      = 32'sd450971566;
	localparam q30_t C_008      = 32'sd85899346;
	localparam q30_t C_050      = 32'sd536870912;
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

	localparam q30_t SIN_K [0:4] = '{32'sd2959, 32'sd213044, 32'sd8947849,
		32'sd178956971, 32'sd1073741824};
	localparam q30_t COS_K [0:4] = '{32'sd296, 32'sd26631, 32'sd1491308,
		32'sd44739243, 32'sd536870912};

	localparam logic signed [63:0] W_MAX = 64'sd131071;
	localparam logic signed [63:0] W_MIN = -64'sd131072;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

	localparam logic [TYPE_W-1:0] WT_RECT     = 4'd1;
	localparam logic [TYPE_W-1:0] WT_TRIANGLE = 4'd2;
	localparam logic [TYPE_W-1:0] WT_COSINE   = 4'd3;
	localparam logic [TYPE_W-1:0] WT_HANNING  = 4'd4;
	localparam logic [TYPE_W-1:0] WT_HAMMING  = 4'd5;
	localparam logic [TYPE_W-1:0] WT_BLACKMAN = 4'd6;
	localparam logic [TYPE_W-1:0] WT_PAPOULIS = 4'd7;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 2'd1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [30:0]         u;
		q30_t                b;
	} wcg_side_t;

	// shift right, magnitude rounded half away from zero
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
		input int unsigned s);
		logic [63:0] m;
		if (s == 0) begin
			return v;
		end
		m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
		m = (m + (64'd1 << (s - 1))) >> s;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

	function automatic q30_t qmul(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		logic signed [63:0] r;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		r = rnd(p, 30);
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

[rtl/wcg_divider.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module wcg_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [wcg_pkg::IDX_W-1:0]   dividend,
	input  logic [wcg_pkg::LEN_W-1:0]   divisor,
	output logic                        out_vld,
	output logic [wcg_pkg::QUO_W-1:0]   quo,
	output logic [wcg_pkg::LEN_W-1:0]   rem
);
	import wcg_pkg::*;

	logic [LEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic             vld_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [LEN_W-1:0] r_in;
		logic [QUO_W-1:0] q_in;
		logic             v_in;
		logic [LEN_W:0]   dbl;
		logic [LEN_W:0]   diff;
		logic             take;

		if (k == 0) begin : g_first
			assign r_in = {1'b0, dividend};
			assign q_in = '0;
			assign v_in = in_vld;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign v_in = vld_s[k-1];
		end

		assign dbl  = {r_in, 1'b0};
		assign take = dbl >= {1'b0, divisor};
		assign diff = dbl - {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[LEN_W-1:0] : dbl[LEN_W-1:0];
				quo_s[k] <= {q_in[QUO_W-2:0], take};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end
	end

	assign out_vld = vld_s[QUO_W-1];
	assign quo     = quo_s[QUO_W-1];
	assign rem     = rem_s[QUO_W-1];

endmodule
`default_nettype wire

[rtl/wcg_sincos.sv]
// pipelined sine and cosine of a phase in turns, octant fold and taylor polynomials
`default_nettype none
module wcg_sincos (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [31:0]   phase,
	output logic          out_vld,
	output wcg_pkg::q30_t sn,
	output wcg_pkg::q30_t cs
);
	import wcg_pkg::*;

	logic [29:0] r;
	logic        big;
	logic [30:0] fold;
	logic [29:0] rr;
	logic [63:0] prod;
	logic [63:0] rad;

	assign r    = phase[29:0];
	assign big  = r > 30'd536870912;
	assign fold = 31'h40000000 - {1'b0, r};
	assign rr   = big ? fold[29:0] : r;
	assign prod = {34'd0, rr} * {31'd0, TWO_PI_Q30};
	assign rad  = prod + 64'h0000_0000_8000_0000;

	// stage 1: radians
	q30_t       x_s1;
	logic [1:0] quad_s1;
	logic       swap_s1;
	logic       vld_s1;
	// stage 2: square
	q30_t       x_s2, x2_s2;
	logic [1:0] quad_s2;
	logic       swap_s2;
	logic       vld_s2;
	// stages 3..6: horner steps
	q30_t       ps_h [HORNER_N];
	q30_t       pc_h [HORNER_N];
	q30_t       x_h  [HORNER_N];
	q30_t       x2_h [HORNER_N];
	logic [1:0] quad_h [HORNER_N];
	logic       swap_h [HORNER_N];
	logic       vld_h  [HORNER_N];
	// stage 7: polynomial results
	q30_t       s0_s7, c0_s7;
	logic [1:0] quad_s7;
	logic       swap_s7;
	logic       vld_s7;
	// stage 8: quadrant
	q30_t       sn_s8, cs_s8;
	logic       vld_s8;

	q30_t ss, cc;
	assign ss = swap_s7 ? c0_s7 : s0_s7;
	assign cc = swap_s7 ? s0_s7 : c0_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= $signed(rad[63:32]);
			quad_s1 <= phase[31:30];
			swap_s1 <= big;

			x_s2    <= x_s1;
			x2_s2   <= qmul(x_s1, x_s1);
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;

			ps_h[0]   <= SIN_K[1] - qmul(x2_s2, SIN_K[0]);
			pc_h[0]   <= COS_K[1] - qmul(x2_s2, COS_K[0]);
			x_h[0]    <= x_s2;
			x2_h[0]   <= x2_s2;
			quad_h[0] <= quad_s2;
			swap_h[0] <= swap_s2;
			for (int j = 1; j < HORNER_N; j++) begin
				ps_h[j]   <= SIN_K[j+1] - qmul(x2_h[j-1], ps_h[j-1]);
				pc_h[j]   <= COS_K[j+1] - qmul(x2_h[j-1], pc_h[j-1]);
				x_h[j]    <= x_h[j-1];
				x2_h[j]   <= x2_h[j-1];
				quad_h[j] <= quad_h[j-1];
				swap_h[j] <= swap_h[j-1];
			end

			s0_s7   <= qmul(x_h[HORNER_N-1], ps_h[HORNER_N-1]);
			c0_s7   <= Q_ONE - qmul(x2_h[HORNER_N-1], pc_h[HORNER_N-1]);
			quad_s7 <= quad_h[HORNER_N-1];
			swap_s7 <= swap_h[HORNER_N-1];

			case (quad_s7)
				2'd0: begin
					sn_s8 <= ss;
					cs_s8 <= cc;
				end
				2'd1: begin
					sn_s8 <= cc;
					cs_s8 <= -ss;
				end
				2'd2: begin
					sn_s8 <= -ss;
					cs_s8 <= -cc;
				end
				default: begin
					sn_s8 <= -cc;
					cs_s8 <= ss;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int j = 0; j < HORNER_N; j++) begin
				vld_h[j] <= 1'b0;
			end
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_h[0] <= vld_s2;
			for (int j = 1; j < HORNER_N; j++) begin
				vld_h[j] <= vld_h[j-1];
			end
			vld_s7 <= vld_h[HORNER_N-1];
			vld_s8 <= vld_s7;
		end
	end

	assign out_vld = vld_s8;
	assign sn      = sn_s8;
	assign cs      = cs_s8;

endmodule
`default_nettype wire

[rtl/wcg_combine.sv]
// window formula per type, output rounding and saturation
`default_nettype none
module wcg_combine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic [wcg_pkg::TYPE_W-1:0]          wtype,
	input  wcg_pkg::q30_t                       sa,
	input  wcg_pkg::q30_t                       ca,
	input  wcg_pkg::q30_t                       cb,
	input  wcg_pkg::wcg_side_t                  side,
	output logic                                out_vld,
	output logic signed [wcg_pkg::WEIGHT_W-1:0] weight,
	output logic [wcg_pkg::STATUS_W-1:0]        status
);
	import wcg_pkg::*;

	function automatic logic signed [33:0] sx34(input q30_t v);
		return $signed({{2{v[31]}}, v});
	endfunction

	q30_t a1, b1, a2, b2;
	q30_t sabs;
	assign sabs = sa[31] ? -sa : sa;

	// hanning 0.5*(1 - c): 1 - c reaches 2^31, so halve it with rounding in 33 bits
	logic [32:0] hv;
	q30_t        hann;
	assign hv   = {1'b0, Q_ONE} - {ca[31], ca} + 33'd1;
	assign hann = $signed(hv[32:1]);

	always_comb begin
		a1 = '0;
		b1 = '0;
		a2 = '0;
		b2 = '0;
		case (wtype)
			WT_HAMMING: begin
				a1 = C_046;
				b1 = ca;
			end
			WT_BLACKMAN: begin
				a1 = C_050;
				b1 = ca;
				a2 = C_008;
				b2 = cb;
			end
			WT_PAPOULIS: begin
				a1 = sabs;
				b1 = INV_PI_Q30;
				a2 = side.b;
				b2 = ca;
			end
			default: begin
				a1 = '0;
			end
		endcase
	end

	q30_t      p1_s1, p2_s1, sa_s1;
	wcg_side_t side_s1;
	logic      vld_s1;

	logic signed [33:0] w;
	logic signed [33:0] d;
	logic signed [33:0] dabs;
	logic signed [63:0] wr;
	logic signed [WEIGHT_W-1:0] wsat;

	assign d    = sx34(Q_ONE) - $signed({3'b000, side_s1.u});
	assign dabs = d[33] ? -d : d;

	always_comb begin
		case (wtype)
			WT_RECT:     w = sx34(Q_ONE);
			WT_TRIANGLE: w = sx34(Q_ONE) - dabs;
			WT_COSINE:   w = sx34(sa_s1);
			WT_HANNING:  w = sx34(p1_s1);
			WT_HAMMING:  w = sx34(C_054) - sx34(p1_s1);
			WT_BLACKMAN: w = sx34(C_042) - sx34(p1_s1) + sx34(p2_s1);
			WT_PAPOULIS: w = sx34(p1_s1) - sx34(p2_s1);
			default:     w = '0;
		endcase
	end

	assign wr = rnd($signed({{30{w[33]}}, w}), 30 - FRACTION_BITS);

	always_comb begin
		if (wr > W_MAX) begin
			wsat = W_MAX[WEIGHT_W-1:0];
		end else if (wr < W_MIN) begin
			wsat = W_MIN[WEIGHT_W-1:0];
		end else begin
			wsat = wr[WEIGHT_W-1:0];
		end
	end

	logic signed [WEIGHT_W-1:0] weight_s2;
	logic [STATUS_W-1:0]        status_s2;
	logic                       vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1     <= (wtype == WT_HANNING) ? hann : qmul(a1, b1);
			p2_s1     <= qmul(a2, b2);
			sa_s1     <= sa;
			side_s1   <= side;
			weight_s2 <= (side_s1.status == ST_OK) ? wsat : '0;
			status_s2 <= side_s1.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign weight  = weight_s2;
	assign status  = status_s2;

endmodule
`default_nettype wire

[rtl/window_coefficient_generator_core.sv]
// top level of the window coefficient generator
//
// usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 writes the
//   window length (13 bits), index 1 the window type (low 4 bits), other indexes are
//   dropped. cfg_ready is always high. write only while no item is in flight.
//   index channel: sample_index transfers on idx_valid with idx_stall low.
//   result channel: weight and status transfer on res_valid with res_stall low.
//   status 0 ok, 1 window type not in 1..7, 2 index not below the length; weight is
//   zero whenever status is not ok. lengths above 4096 act as 4096.
// timing
//   one item per cycle sustained while no result is stalled; from index transfer to
//   result: input register, 33 divider stages (one quotient bit each), phase
//   register, 8 sine/cosine stages, 2 combine stages ending in the output register.
// reset
//   arst_n clears all valid bits; length resets to 1024, type to rectangular.
// stall
//   while a result waits under res_stall the whole pipeline freezes and idx_stall
//   rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module window_coefficient_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wcg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wcg_pkg::LEN_W-1:0]           cfg_data,
	input  logic                                idx_valid,
	output logic                                idx_stall,
	input  logic [wcg_pkg::IDX_W-1:0]           sample_index,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [wcg_pkg::WEIGHT_W-1:0] weight,
	output logic [wcg_pkg::STATUS_W-1:0]        status
);
	import wcg_pkg::*;

	localparam logic [16:0] MAX_LEN_V = 17'(MAX_LENGTH);

	// configuration registers
	logic [LEN_W-1:0]  len_q;
	logic [TYPE_W-1:0] type_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 13'd1024;
			type_q <= WT_RECT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LENGTH: len_q  <= cfg_data;
				REG_TYPE:   type_q <= cfg_data[TYPE_W-1:0];
				default:    len_q  <= len_q;
			endcase
		end
	end

	// effective length, clamped to MAX_LENGTH
	logic [LEN_W-1:0] n_eff;
	assign n_eff = ({4'd0, len_q} > MAX_LEN_V) ? MAX_LEN_V[LEN_W-1:0] : len_q;

	// one global advance: everything moves unless the output is held
	logic en;
	assign en        = !(res_valid && res_stall);
	assign idx_stall = !en;

	// input stage: status and the sign of 2i - n are known here
	logic                type_ok;
	logic [STATUS_W-1:0] stat_in;
	assign type_ok = (type_q >= WT_RECT) && (type_q <= WT_PAPOULIS);
	always_comb begin
		if (!type_ok) begin
			stat_in = ST_BAD_TYPE;
		end else if ({1'b0, sample_index} >= n_eff) begin
			stat_in = ST_BAD_INDEX;
		end else begin
			stat_in = ST_OK;
		end
	end

	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [STATUS_W-1:0] stat_s1;
	logic                ge_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= sample_index;
			stat_s1 <= stat_in;
			ge_s1   <= {sample_index, 1'b0} >= n_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= idx_valid;
		end
	end

	// i*2^33/n; all phases and the triangle ramp are slices of this quotient
	logic             dv_vld;
	logic [QUO_W-1:0] dv_quo;
	logic [LEN_W-1:0] dv_rem;

	wcg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.dividend (idx_s1),
		.divisor  (n_eff),
		.out_vld  (dv_vld),
		.quo      (dv_quo),
		.rem      (dv_rem)
	);

	// side information riding alongside the divider
	logic [STATUS_W-1:0] stat_d [DIV_LAT];
	logic                ge_d   [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			stat_d[0] <= stat_s1;
			ge_d[0]   <= ge_s1;
			for (int k = 1; k < DIV_LAT; k++) begin
				stat_d[k] <= stat_d[k-1];
				ge_d[k]   <= ge_d[k-1];
			end
		end
	end

	// phase stage
	logic [30:0] u;
	logic        exact;
	logic [31:0] b_hi;
	q30_t        b_val;
	logic [31:0] ph_a;

	assign u     = dv_quo[32:2];
	// i*2^31/n divides evenly: ceil equals floor
	assign exact = (dv_quo[1:0] == 2'd0) && (dv_rem == '0);
	assign b_hi  = 32'h8000_0000 - {1'b0, u};
	// papoulis b taken from the same quotient, split on the sign of 2i - n
	assign b_val = ge_d[DIV_LAT-1] ? $signed(b_hi) : $signed({1'b0, u} + {31'd0, !exact});
	// half phase for the cosine window, plain phase otherwise
	assign ph_a  = (type_q == WT_COSINE) ? {1'b0, u} : dv_quo[32:1];

	logic        vld_s2;
	logic [31:0] ph_a_s2;
	logic [31:0] ph_b_s2;
	wcg_side_t   side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_a_s2        <= ph_a;
			ph_b_s2        <= dv_quo[31:0];
			side_s2.status <= stat_d[DIV_LAT-1];
			side_s2.u      <= u;
			side_s2.b      <= b_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dv_vld;
		end
	end

	// two sine/cosine units: plain (or half) phase, and the double phase for blackman
	logic sc_vld;
	q30_t sa, ca, cb;

	wcg_sincos u_sc_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.phase   (ph_a_s2),
		.out_vld (sc_vld),
		.sn      (sa),
		.cs      (ca)
	);

	wcg_sincos u_sc_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.phase   (ph_b_s2),
		.out_vld (),
		.sn      (),
		.cs      (cb)
	);

	wcg_side_t side_d [SC_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s2;
			for (int k = 1; k < SC_LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// type_q used as is: user must change type only with the pipe empty; unenforced
	wcg_combine u_cmb (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sc_vld),
		.wtype   (type_q),
		.sa      (sa),
		.ca      (ca),
		.cb      (cb),
		.side    (side_d[SC_LAT-1]),
		.out_vld (res_valid),
		.weight  (weight),
		.status  (status)
	);

	// any error status carries a zero weight
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != ST_OK) |-> (weight == '0))
		else $error("nonzero weight with error status");

	// input is held back only while a result sits stalled
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		idx_stall |-> (res_valid && res_stall))
		else $error("index stalled without output stall");

	// an item marked ok lies inside the window
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (stat_s1 == ST_OK) |-> ({1'b0, idx_s1} < n_eff))
		else $error("ok status with index beyond length");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for the window coefficient generator core
`default_nettype none
module tb_top;
	import wcg_pkg::*;

	// register indexes that the block drops
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	// pipeline depth plus margin, waited before each group of register writes
	localparam int SETTLE_CYCLES = 60;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [LEN_W-1:0]           cfg_data;
	logic                       idx_valid;
	logic                       idx_stall;
	logic [IDX_W-1:0]           sample_index;
	logic                       res_valid;
	logic                       res_stall;
	logic signed [WEIGHT_W-1:0] weight;
	logic [STATUS_W-1:0]        status;

	// expected weights for the current length and type, checked in arrival order
	class weight_scoreboard;
		logic [LEN_W-1:0]    win_len;
		logic [TYPE_W-1:0]   win_type;
		logic [WEIGHT_W-1:0] pending_weight[$];
		logic [STATUS_W-1:0] pending_status[$];
		int                  errors;
		int                  checked;

		function new();
			win_len  = 13'd1024;
			win_type = WT_RECT;
			errors   = 0;
			checked  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] d);
			if (idx == REG_LENGTH) begin
				win_len = d;
			end else if (idx == REG_TYPE) begin
				win_type = d[TYPE_W-1:0];
			end
		endfunction

		// shift right, magnitude rounded half away from zero
		function longint round_shift(longint v, int s);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (64'sd1 <<< (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		endfunction

		function longint fx_mul(longint a, longint b);
			return round_shift(a * b, 30);
		endfunction

		// taylor sine/cosine in q30 for 0 <= x <= pi/4
		function void taylor(longint x, output longint s, output longint c);
			longint x2, p;
			x2 = fx_mul(x, x);
			p = 2959;
			p = 213044 - fx_mul(x2, p);
			p = 8947849 - fx_mul(x2, p);
			p = 178956971 - fx_mul(x2, p);
			p = 1073741824 - fx_mul(x2, p);
			s = fx_mul(x, p);
			p = 296;
			p = 26631 - fx_mul(x2, p);
			p = 1491308 - fx_mul(x2, p);
			p = 44739243 - fx_mul(x2, p);
			p = 536870912 - fx_mul(x2, p);
			c = 1073741824 - fx_mul(x2, p);
		endfunction

		// sine and cosine of a phase given in q32 turns
		function void turn_sincos(logic [31:0] t, output longint sn, output longint cs);
			longint r, x, s0, c0;
			bit swap;
			r = longint'(t[29:0]);
			swap = 0;
			if (r > (64'sd1 <<< 29)) begin
				r = (64'sd1 <<< 30) - r;
				swap = 1;
			end
			x = (r * longint'(TWO_PI_Q30) + (64'sd1 <<< 31)) >>> 32;
			if (swap) begin
				taylor(x, c0, s0);
			end else begin
				taylor(x, s0, c0);
			end
			case (t[31:30])
				2'd0: begin sn = s0; cs = c0; end
				2'd1: begin sn = c0; cs = -s0; end
				2'd2: begin sn = -s0; cs = -c0; end
				default: begin sn = -c0; cs = s0; end
			endcase
		endfunction

		function void note_input(logic [IDX_W-1:0] idx);
			longint n, i, w, s, c, s2, c2, a, b, d;
			logic [63:0] q;
			logic [STATUS_W-1:0] st;
			n = (win_len > MAX_LENGTH) ? MAX_LENGTH : longint'(win_len);
			i = longint'(idx);
			w = 0;
			st = ST_OK;
			if (win_type < WT_RECT || win_type > WT_PAPOULIS) begin
				st = ST_BAD_TYPE;
			end else if (i >= n) begin
				st = ST_BAD_INDEX;
			end else begin
				q = (i <<< 32) / n;
				turn_sincos(q[31:0], s, c);
				case (win_type)
					WT_RECT: w = longint'(Q_ONE);
					WT_TRIANGLE: begin
						d = longint'(Q_ONE) - ((i <<< 31) / n);
						w = longint'(Q_ONE) - ((d < 0) ? -d : d);
					end
					WT_COSINE: begin
						q = (i <<< 31) / n;
						turn_sincos(q[31:0], s2, c2);
						w = s2;
					end
					WT_HANNING: w = fx_mul(longint'(C_050), longint'(Q_ONE) - c);
					WT_HAMMING: w = longint'(C_054) - fx_mul(longint'(C_046), c);
					WT_BLACKMAN: begin
						q = (i <<< 33) / n;
						turn_sincos(q[31:0], s2, c2);
						w = longint'(C_042) - fx_mul(longint'(C_050), c)
							+ fx_mul(longint'(C_008), c2);
					end
					default: begin
						// papoulis form kept as a - b*c
						a = fx_mul((s < 0) ? -s : s, longint'(INV_PI_Q30));
						d = 2 * i - n;
						if (d < 0) d = -d;
						b = longint'(Q_ONE) - ((d <<< 30) / n);
						w = a - fx_mul(b, c);
					end
				endcase
				w = round_shift(w, 30 - FRACTION_BITS);
				if (w > 131071) w = 131071;
				if (w < -131072) w = -131072;
			end
			pending_weight.push_back(w[WEIGHT_W-1:0]);
			pending_status.push_back(st);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [WEIGHT_W-1:0] w, logic [STATUS_W-1:0] st);
			logic [WEIGHT_W-1:0] ew;
			logic [STATUS_W-1:0] es;
			if (pending_weight.size() == 0) begin
				report($sformatf("unexpected result weight %0d status %0d",
					$signed(w), st));
			end else begin
				ew = pending_weight.pop_front();
				es = pending_status.pop_front();
				checked++;
				if (w !== ew) report($sformatf("weight %0d, expected %0d",
					$signed(w), $signed(ew)));
				if (st !== es) report($sformatf("status %0d, expected %0d", st, es));
			end
		endtask
	endclass

	weight_scoreboard sb = new();
	bit idle_on = 1;
	int sent = 0;
	int phases = 0;

	window_coefficient_generator_core u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one nonblocking drive per cycle keeps the stall random
	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		idx_valid = 0;
		sample_index = '0;
		res_stall = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n) res_stall <= idle_on && ($urandom_range(99) < 17);
	end

	// monitors: note each accepted index and config write, check each result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (idx_valid && !idx_stall) sb.note_input(sample_index);
			if (res_valid && !res_stall) sb.check_result(weight, status);
		end
	end

	// wait for every pending result, then let the pipeline empty
	task drain();
		while (sb.pending_weight.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task set_window(logic [LEN_W-1:0] len, logic [TYPE_W-1:0] typ);
		if (idx_valid) begin
			idx_valid <= 0;
			@(posedge clk);
		end
		drain();
		write_reg(REG_LENGTH, len);
		write_reg(REG_TYPE, {9'd0, typ});
		phases++;
	endtask

	// valid stays high between back-to-back transfers; with idle_on, a random gap may come first
	task send_index(logic [IDX_W-1:0] v);
		if (idle_on && $urandom_range(99) < 20) begin
			idx_valid <= 0;
			@(posedge clk);
		end
		idx_valid <= 1;
		sample_index <= v;
		do @(posedge clk); while (idx_stall);
		sent++;
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		logic [TYPE_W-1:0] typ;
		int n;
		@(posedge arst_n);
		@(posedge clk);

		// directed: full length, each type at the edges and inside
		for (int t = WT_RECT; t <= WT_PAPOULIS; t++) begin
			set_window(13'd4096, t[TYPE_W-1:0]);
			send_index(12'd0);
			send_index(12'd1365);
			send_index(12'd4095);
		end
		// invalid types take precedence over the index check
		set_window(13'd0, 4'd0);
		send_index(12'd4095);
		set_window(13'd8191, 4'd15);
		send_index(12'd0);
		// zero length rejects every index
		set_window(13'd0, WT_HAMMING);
		send_index(12'd0);
		// shortest window, then index beyond it
		set_window(13'd1, WT_PAPOULIS);
		send_index(12'd0);
		send_index(12'd1);
		// oversize length clamps to the maximum
		set_window(13'd8191, WT_TRIANGLE);
		send_index(12'd4095);
		idx_valid <= 0;
		@(posedge clk);
		drain();
		// writes to the dropped register indexes, which must not disturb the settings; no check follows
		write_reg(REG_SPARE_A, 13'h1fff);
		write_reg(REG_SPARE_B, 13'h0003);

		// random phases, mostly in-range indexes
		for (int p = 0; p < 13; p++) begin
			idle_on = !(p == 5 || p == 6);
			case ($urandom_range(7))
				0: len = 13'd1;
				1: len = 13'd2;
				2: len = 13'd4096;
				3: len = LEN_W'($urandom_range(4097, 8191));
				4: len = $urandom_range(0, 3) == 0 ? 13'd0 : 13'd3;
				default: len = LEN_W'($urandom_range(1, 4096));
			endcase
			typ = ($urandom_range(9) == 0) ? TYPE_W'($urandom_range(15))
				: TYPE_W'($urandom_range(WT_RECT, WT_PAPOULIS));
			set_window(len, typ);
			n = (len > MAX_LENGTH) ? MAX_LENGTH : int'(len);
			repeat (50) begin
				if (n > 0 && $urandom_range(9) != 0) begin
					send_index(IDX_W'($urandom_range(n - 1)));
				end else begin
					send_index(IDX_W'($urandom_range(4095)));
				end
			end
		end
		idx_valid <= 0;
		idle_on = 1;
		drain();

		$display("covered %0d indexes over %0d length/type settings, %0d results checked",
			sent, phases, sb.checked);
		if (sb.errors == 0 && sb.pending_weight.size() == 0) begin
			$display("PASS window_coefficient_generator_core");
		end else begin
			$display("FAIL window_coefficient_generator_core");
		end
		$finish;
	end

	// timeout guard
	initial begin
		#3000000;
		$display("FAIL window_coefficient_generator_core");
		$finish;
	end

endmodule
`default_nettype wire
